// ===== sv/dkrh_pkg.sv =====
package dkrh_pkg;

	localparam int MAX_KMER = 32;
	localparam int KLEN_W   = 6;
	localparam int STRIDE_W = 8;
	localparam int CHAR_W   = 8;
	localparam int RID_W    = 32;
	localparam int POS_W    = 16;
	localparam int CODE_W   = 2;
	localparam int HASH_W   = CODE_W * MAX_KMER;
	localparam int CFG_IDX_W = 1;

	localparam logic [KLEN_W-1:0]   KLEN_RESET   = KLEN_W'(16);
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KMER_LENGTH = 1'b0,
		REG_SAVE_STRIDE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		STATUS_KMER    = 1'b0,
		STATUS_UNKNOWN = 1'b1
	} status_t;

	// per-beat control broadcast to every cell of the hash chain
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		status_t             status;
		logic [HASH_W-1:0]   kmer_hash;
		logic [RID_W-1:0]    read_id;
		logic [POS_W-1:0]    base_position;
	} result_t;

endpackage

// ===== sv/dkrh_cell.sv =====
module dkrh_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dkrh_pkg::cell_ctrl_t        ctrl,
	input  logic                        keep,
	input  logic [dkrh_pkg::CODE_W-1:0] din,
	output logic [dkrh_pkg::CODE_W-1:0] dout,
	output logic [dkrh_pkg::CODE_W-1:0] shifted
);

	logic [dkrh_pkg::CODE_W-1:0] base_q;

	// value this cell takes on a shift, zero beyond the k-mer length
	assign shifted = keep ? din : '0;
	assign dout    = base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (ctrl.clear) begin
			base_q <= '0;
		end else if (ctrl.shift) begin
			base_q <= shifted;
		end
	end

endmodule

// ===== sv/dkrh_ctrl.sv =====
module dkrh_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dkrh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dkrh_pkg::STRIDE_W-1:0]   cfg_data,
	input  logic                            fire,
	input  logic [dkrh_pkg::CHAR_W-1:0]     base_char,
	input  logic                            last_of_read,
	output dkrh_pkg::cell_ctrl_t            cell_ctrl,
	output logic [dkrh_pkg::CODE_W-1:0]     code,
	output logic [dkrh_pkg::KLEN_W-1:0]     k_eff,
	output logic                            res_valid,
	output dkrh_pkg::status_t               res_status,
	output logic [dkrh_pkg::POS_W-1:0]      res_position
);

	localparam logic [dkrh_pkg::KLEN_W-1:0] RUN_MAX = dkrh_pkg::KLEN_W'(dkrh_pkg::MAX_KMER);

	logic [dkrh_pkg::KLEN_W-1:0]   kmer_length_q;
	logic [dkrh_pkg::STRIDE_W-1:0] save_stride_q;
	logic [dkrh_pkg::KLEN_W-1:0]   valid_run_q;
	logic [dkrh_pkg::STRIDE_W-1:0] countdown_q;
	logic [dkrh_pkg::POS_W-1:0]    position_q;

	logic [dkrh_pkg::CHAR_W-1:0]   uc;
	logic                          is_base;
	logic                          is_amb;
	logic [dkrh_pkg::KLEN_W-1:0]   run_inc;
	logic                          full;
	logic [dkrh_pkg::STRIDE_W-1:0] cd_dec;
	logic [dkrh_pkg::STRIDE_W-1:0] stride_eff;
	logic                          emit;

	always_comb begin
		uc = base_char;
		if (base_char >= "a" && base_char <= "z") begin
			uc = base_char - dkrh_pkg::CHAR_W'(32);
		end
	end

	always_comb begin
		is_base = 1'b1;
		is_amb  = 1'b0;
		code    = '0;
		unique case (uc)
			"A": code = 2'd0;
			"C": code = 2'd1;
			"G": code = 2'd2;
			"T": code = 2'd3;
			"N", "X", "R", "Y", "M", "S", "K", "W", "B", "D", "H", "V", "*": begin
				is_base = 1'b0;
				is_amb  = 1'b1;
			end
			default: is_base = 1'b0;
		endcase
	end

	always_comb begin
		k_eff = kmer_length_q;
		if (kmer_length_q == '0) begin
			k_eff = dkrh_pkg::KLEN_W'(1);
		end else if (kmer_length_q > RUN_MAX) begin
			k_eff = RUN_MAX;
		end
	end

	assign stride_eff = (save_stride_q == '0) ? dkrh_pkg::STRIDE_W'(1) : save_stride_q;
	assign run_inc    = (valid_run_q >= RUN_MAX) ? RUN_MAX : valid_run_q + 1'b1;
	assign full       = run_inc >= k_eff;
	assign cd_dec     = countdown_q - 1'b1;
	assign emit       = is_base && full && (cd_dec == '0);

	assign cell_ctrl.shift = fire && is_base;
	assign cell_ctrl.clear = fire && (is_amb || last_of_read);

	assign res_valid    = emit || (!is_base && !is_amb);
	assign res_status   = is_base ? dkrh_pkg::STATUS_KMER : dkrh_pkg::STATUS_UNKNOWN;
	assign res_position = position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= dkrh_pkg::KLEN_RESET;
			save_stride_q <= dkrh_pkg::STRIDE_RESET;
		end else if (cfg_we) begin
			unique case (dkrh_pkg::cfg_reg_t'(cfg_index))
				dkrh_pkg::REG_KMER_LENGTH: kmer_length_q <= cfg_data[dkrh_pkg::KLEN_W-1:0];
				dkrh_pkg::REG_SAVE_STRIDE: save_stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_run_q <= '0;
			countdown_q <= dkrh_pkg::STRIDE_W'(1);
			position_q  <= '0;
		end else if (fire) begin
			if (last_of_read) begin
				valid_run_q <= '0;
				countdown_q <= dkrh_pkg::STRIDE_W'(1);
				position_q  <= '0;
			end else begin
				position_q <= position_q + 1'b1;
				if (is_base) begin
					valid_run_q <= run_inc;
					if (full) begin
						countdown_q <= emit ? stride_eff : cd_dec;
					end
				end else if (is_amb) begin
					valid_run_q <= '0;
					countdown_q <= dkrh_pkg::STRIDE_W'(1);
				end
			end
		end
	end

endmodule

// ===== sv/dna_kmer_rolling_hasher_unit.sv =====
// a result beat is registered into the output register, or into the skid while the output is held
// throughput: one input beat per cycle while s_tready is high; the hash is a chain of 32 two-bit
// cells shifted together, counters update in the same cycle
// a two-entry output stage (register plus skid) keeps s_tready high while only one result waits
// reset (arst_n low): hash, run and position clear, stride countdown to one, registers to defaults
module dna_kmer_rolling_hasher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dkrh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dkrh_pkg::STRIDE_W-1:0]   cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,  // base_char[7:0], read_id[39:8]
	input  logic                            s_tlast,  // last_of_read
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [111:0]                    m_tdata,  // kmer_hash[63:0], out_read_id[95:64],
	                                                  // base_position[111:96]
	output logic                            m_tuser   // status
);

	logic                            fire;
	dkrh_pkg::cell_ctrl_t            cell_ctrl;
	logic [dkrh_pkg::CODE_W-1:0]     code;
	logic [dkrh_pkg::KLEN_W-1:0]     k_eff;
	logic                            res_valid;
	dkrh_pkg::status_t               res_status;
	logic [dkrh_pkg::POS_W-1:0]      res_position;

	logic [dkrh_pkg::HASH_W-1:0]     chain_q;
	logic [dkrh_pkg::HASH_W-1:0]     chain_shift;

	dkrh_pkg::result_t               res_new;
	dkrh_pkg::result_t               out_q;
	dkrh_pkg::result_t               skid_q;
	logic                            out_valid_q;
	logic                            skid_valid_q;
	logic                            push;
	logic                            out_free;

	assign s_tready = !skid_valid_q;
	assign fire     = s_tvalid && s_tready;

	dkrh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fire         (fire),
		.base_char    (s_tdata[7:0]),
		.last_of_read (s_tlast),
		.cell_ctrl    (cell_ctrl),
		.code         (code),
		.k_eff        (k_eff),
		.res_valid    (res_valid),
		.res_status   (res_status),
		.res_position (res_position)
	);

	for (genvar i = 0; i < dkrh_pkg::MAX_KMER; i++) begin : g_cell
		localparam logic [dkrh_pkg::KLEN_W-1:0] IDX = dkrh_pkg::KLEN_W'(i);
		logic [dkrh_pkg::CODE_W-1:0] din;
		if (i == 0) begin : g_head
			assign din = code;
		end else begin : g_link
			assign din = chain_q[dkrh_pkg::CODE_W*(i-1) +: dkrh_pkg::CODE_W];
		end
		dkrh_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.keep    (IDX < k_eff),
			.din     (din),
			.dout    (chain_q[dkrh_pkg::CODE_W*i +: dkrh_pkg::CODE_W]),
			.shifted (chain_shift[dkrh_pkg::CODE_W*i +: dkrh_pkg::CODE_W])
		);
	end

	always_comb begin
		res_new.status        = res_status;
		res_new.kmer_hash     = (res_status == dkrh_pkg::STATUS_KMER) ? chain_shift : '0;
		res_new.read_id       = s_tdata[39:8];
		res_new.base_position = res_position;
	end

	assign push     = fire && res_valid;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res_new;
				end
			end else if (push) begin
				out_q <= res_new;
			end
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_q.base_position, out_q.read_id, out_q.kmer_hash};

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 800_000;
	localparam int BEATS_PER_PHASE = 140;

	typedef enum logic [1:0] {
		CH_BASE,
		CH_AMBIG,
		CH_OTHER
	} char_kind_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [dkrh_pkg::CFG_IDX_W-1:0] cfg_index = dkrh_pkg::REG_KMER_LENGTH;
	logic [dkrh_pkg::STRIDE_W-1:0]  cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [39:0]                    s_tdata = '0;   // base_char[7:0], read_id[39:8]
	logic                           s_tlast = 1'b0; // last_of_read
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [111:0]                   m_tdata;        // kmer_hash[63:0], out_read_id[95:64],
	                                                // base_position[111:96]
	logic                           m_tuser;        // status

	dna_kmer_rolling_hasher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register copies and per-read hashing state
	logic [dkrh_pkg::KLEN_W-1:0]   reg_klen = dkrh_pkg::KLEN_RESET;
	logic [dkrh_pkg::STRIDE_W-1:0] reg_stride = dkrh_pkg::STRIDE_RESET;
	logic [dkrh_pkg::HASH_W-1:0]   roll_hash = '0;
	logic [5:0]                    run_len = '0;
	logic [7:0]                    save_cd = 8'd1;
	logic [dkrh_pkg::POS_W-1:0]    next_pos = '0;

	dkrh_pkg::result_t expected_kmers [$];

	int src_mode = 0;
	int sink_mode = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int err_count = 0;
	int results_checked = 0;
	int beats_sent = 0;
	int kmer_hits = 0;
	int unknown_hits = 0;
	int settings_count = 1;

	// 0: never idle, 1: mostly short gaps, 2: frequent gaps, some long
	function automatic int pick_idle(int mode);
		int roll;
		roll = $urandom_range(0, 99);
		case (mode)
			1: begin
				if (roll < 75) return 0;
				if (roll < 95) return $urandom_range(1, 3);
				return $urandom_range(8, 24);
			end
			2: begin
				if (roll < 40) return 0;
				if (roll < 85) return $urandom_range(1, 4);
				return $urandom_range(10, 30);
			end
			default: return 0;
		endcase
	endfunction

	function automatic char_kind_t classify(input logic [7:0] ch, output logic [1:0] code);
		logic [7:0] up;
		char_kind_t kind;
		up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
		code = 2'd0;
		kind = CH_OTHER;
		case (up)
			"A": kind = CH_BASE;
			"C": begin
				kind = CH_BASE;
				code = 2'd1;
			end
			"G": begin
				kind = CH_BASE;
				code = 2'd2;
			end
			"T": begin
				kind = CH_BASE;
				code = 2'd3;
			end
			"N", "X", "R", "Y", "M", "S", "K", "W", "B", "D", "H", "V", "*": kind = CH_AMBIG;
			default: ;
		endcase
		return kind;
	endfunction

	function automatic logic [7:0] rand_base();
		string pool;
		pool = "ACGTacgt";
		return pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [7:0] rand_ambig();
		string pool;
		pool = "NXRYMSKWBDHVnxrymskwbdhv*";
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	function automatic logic [7:0] rand_unknown();
		logic [7:0] ch;
		logic [1:0] code;
		do begin
			ch = 8'($urandom_range(0, 255));
		end while (classify(ch, code) != CH_OTHER);
		return ch;
	endfunction

	function automatic void clear_read();
		roll_hash = '0;
		run_len = '0;
		save_cd = 8'd1;
		next_pos = '0;
	endfunction

	// advance the hashing state by one accepted beat, queue the result it causes
	function automatic void track_base(logic [7:0] ch, logic [31:0] rid, logic last);
		logic [1:0] code;
		char_kind_t kind;
		int k;
		logic [dkrh_pkg::HASH_W-1:0] mask;
		logic [7:0] stride;
		dkrh_pkg::result_t rec;
		kind = classify(ch, code);
		k = (reg_klen == 0) ? 1 : (reg_klen > dkrh_pkg::MAX_KMER) ? dkrh_pkg::MAX_KMER
			: int'(reg_klen);
		mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
		stride = (reg_stride == 0) ? 8'd1 : reg_stride;
		rec.read_id = rid;
		rec.base_position = next_pos;
		case (kind)
			CH_BASE: begin
				roll_hash = ((roll_hash << 2) & mask) + 64'(code);
				if (run_len < 6'd32) run_len = run_len + 6'd1;
				if (run_len >= k) begin
					save_cd = save_cd - 8'd1;
					if (save_cd == 0) begin
						rec.status = dkrh_pkg::STATUS_KMER;
						rec.kmer_hash = roll_hash;
						expected_kmers.insert(expected_kmers.size(), rec);
						kmer_hits++;
						save_cd = stride;
					end
				end
			end
			CH_AMBIG: begin
				roll_hash = '0;
				run_len = '0;
				save_cd = 8'd1;
			end
			default: begin
				rec.status = dkrh_pkg::STATUS_UNKNOWN;
				rec.kmer_hash = '0;
				expected_kmers.insert(expected_kmers.size(), rec);
				unknown_hits++;
			end
		endcase
		next_pos = next_pos + 16'd1;
		if (last) clear_read();
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		err_count++;
		$display("mismatch at result %0d: %s got %h want %h", results_checked, what, got,
			want);
	endtask

	// result side: check accepted beats, then pick m_tready for the next cycle
	always @(posedge clk) begin : result_sink
		dkrh_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_kmers.size() == 0) begin
				report_mismatch("result beat with nothing pending", m_tdata[63:0], '0);
			end else begin
				want = expected_kmers.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
				if (m_tdata[63:0] !== want.kmer_hash)
					report_mismatch("kmer_hash", m_tdata[63:0], want.kmer_hash);
				if (m_tdata[95:64] !== want.read_id)
					report_mismatch("out_read_id", 64'(m_tdata[95:64]), 64'(want.read_id));
				if (m_tdata[111:96] !== want.base_position)
					report_mismatch("base_position", 64'(m_tdata[111:96]),
						64'(want.base_position));
			end
			results_checked++;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = pick_idle(sink_mode);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_beat(logic [7:0] ch, logic [31:0] rid, logic last);
		int gap;
		gap = pick_idle(src_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rid, ch};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		track_base(ch, rid, last);
		beats_sent++;
	endtask

	task automatic send_string(string chars, logic [31:0] rid, logic last_at_end);
		for (int i = 0; i < chars.len(); i++)
			send_beat(chars[i], rid, last_at_end && i == chars.len() - 1);
	endtask

	// stop the stream and let every pending result drain, then keep idling
	// for a beat that produces nothing
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_kmers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(dkrh_pkg::cfg_reg_t idx, logic [7:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == dkrh_pkg::REG_KMER_LENGTH) reg_klen = value[dkrh_pkg::KLEN_W-1:0];
		else reg_stride = value;
	endtask

	task automatic send_read(int len, int amb_pct, int unk_pct);
		logic [31:0] rid;
		int roll;
		logic [7:0] ch;
		rid = $urandom();
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < amb_pct) ch = rand_ambig();
			else if (roll < amb_pct + unk_pct) ch = rand_unknown();
			else ch = rand_base();
			send_beat(ch, rid, i == len - 1);
		end
	endtask

	// reset registers (k 16, stride 4): mixed case bases, clears, unknowns, end of read
	task automatic test_directed_cases();
		src_mode = 1;
		sink_mode = 1;
		send_string("acgtACGTTGCAtgcA", 32'h0000_0000, 1'b0);
		send_string("*", 32'h0000_0000, 1'b0);
		send_beat(8'h00, 32'h0000_0000, 1'b0);
		send_beat(8'hFF, 32'h0000_0000, 1'b1);
		send_string("xZg", 32'hFFFF_FFFF, 1'b1);
	endtask

	// well-formed reads with random content under a spread of register settings
	task automatic test_random_reads();
		int phase_k [7] = '{1, 0, 32, 63, 2, 8'hC5, 16};
		int phase_s [7] = '{1, 0, 1, 7, 255, 3, 4};
		int k_val;
		int s_val;
		int start;
		int len;
		for (int p = 0; p < 10; p++) begin
			if (p < 7) begin
				k_val = phase_k[p];
				s_val = phase_s[p];
			end else begin
				k_val = $urandom_range(0, 63);
				s_val = $urandom_range(0, 255);
			end
			write_reg(dkrh_pkg::REG_KMER_LENGTH, 8'(k_val));
			write_reg(dkrh_pkg::REG_SAVE_STRIDE, 8'(s_val));
			settings_count++;
			src_mode = p % 3;
			sink_mode = (p + 1) % 3;
			start = beats_sent;
			while (beats_sent - start < BEATS_PER_PHASE) begin
				len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 48)
					: $urandom_range(49, 140);
				send_read(len, 3, 2);
				if ($urandom_range(0, 19) == 0) wait_idle();
			end
		end
	endtask

	// arbitrary bytes, ids and end marks, both sides busy
	task automatic test_noise();
		logic [7:0] ch;
		write_reg(dkrh_pkg::REG_KMER_LENGTH, 8'd4);
		write_reg(dkrh_pkg::REG_SAVE_STRIDE, 8'd2);
		settings_count++;
		src_mode = 2;
		sink_mode = 2;
		for (int i = 0; i < 230; i++) begin
			ch = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : rand_base();
			send_beat(ch, $urandom(), $urandom_range(0, 99) < 8);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_reads();
		test_noise();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("run covered %0d input beats over %0d register settings", beats_sent,
			settings_count);
		$display("checked %0d results (%0d k-mers, %0d unknown characters), %0d mismatches",
			results_checked, kmer_hits, unknown_hits, err_count);
		if (err_count == 0 && expected_kmers.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== dna_kmer_rolling_hasher_unit.f =====
sv/dkrh_pkg.sv
sv/dkrh_cell.sv
sv/dkrh_ctrl.sv
sv/dna_kmer_rolling_hasher_unit.sv
tb/sv/tb_top.sv
